[hw/rtl/pwre_pkg.sv]
// Shared types and constants of the per-worker round-trip estimator.
// No dependencies; used by pwre_div and per_worker_rtt_rto_estimator.
`default_nettype none

package pwre_pkg;

  // field widths of the result item
  localparam int RTO_W  = 27;
  localparam int RATE_W = 20;

  // item modes
  localparam logic [1:0] MODE_SAMPLE  = 2'd0;
  localparam logic [1:0] MODE_TIMEOUT = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;

  // estimator constants
  localparam logic [RATE_W-1:0] RATE_NUM   = 20'd1000000;
  localparam logic [RATE_W-1:0] RATE_RESET = 20'd100000;
  localparam logic [RTO_W-1:0]  RTO_RESET  = 27'd200000;
  localparam logic [RTO_W-1:0]  RTO_MAX    = '1;
  localparam int unsigned       SEED_FLOOR = 50000;

  // input item
  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  worker;
    logic [23:0] rtt_us;
  } req_t;

  // result item
  typedef struct packed {
    logic [RTO_W-1:0]  rto_us;
    logic [RATE_W-1:0] reqs_per_sec;
  } rsp_t;

endpackage

`default_nettype wire

[hw/rtl/per_worker_rtt_rto_estimator.sv]
// Per-worker round-trip estimator: one entry per worker in a single RAM,
// read, updated and written back for each item; every item returns the
// entry's timeout and requests-per-second after its own update. A sample
// item goes through a RAM read, three update steps, the bit-serial divide
// for 1e6/srtt (20 quotient bits), then the write-back together with the
// result. Timeout and query items skip the third update step and the
// divide. The block returns to idle after each write-back and accepts the
// next item there. Items are handled one at a time; the next item is taken
// while a result still waits on rsp, and its write-back then waits until
// that result is taken.
// After reset a clearing pass loads the reset entry into every worker
// before the first item is accepted.
// Depends on pwre_pkg, pwre_ram and pwre_div.
`default_nettype none

module per_worker_rtt_rto_estimator #(
  parameter int NUM_WORKERS = 16,
  parameter int RTT_BITS    = 24
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire pwre_pkg::req_t  req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output pwre_pkg::rsp_t       rsp
);

  localparam int IW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int SW = (RTT_BITS > 24) ? RTT_BITS : 24;
  localparam int TW = (RTT_BITS + 3 > pwre_pkg::RTO_W) ? RTT_BITS + 3 : pwre_pkg::RTO_W + 1;
  localparam int AW = RTT_BITS + 6;
  localparam logic [RTT_BITS-1:0] RTT_MAX = '1;

  typedef struct packed {
    logic [RTT_BITS-1:0]         srtt;
    logic [RTT_BITS-1:0]         mdev;
    logic [RTT_BITS-1:0]         maxdev;
    logic [RTT_BITS-1:0]         rttvar;
    logic [pwre_pkg::RATE_W-1:0] rate;
    logic [pwre_pkg::RTO_W-1:0]  rto;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_UPD1, S_UPD2, S_UPD3, S_DIV, S_WRITE
  } state_t;

  localparam entry_t RESET_ENTRY = '{
    srtt:   '0,
    mdev:   '0,
    maxdev: '0,
    rttvar: '0,
    rate:   pwre_pkg::RATE_RESET,
    rto:    pwre_pkg::RTO_RESET
  };

  // worker index modulo NUM_WORKERS, as a small constant table
  function automatic logic [IW-1:0] worker_mod(input logic [3:0] w);
    logic [IW-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (w == 4'(i)) begin
        r = IW'(i % NUM_WORKERS);
      end
    end
    return r;
  endfunction

  state_t              state;
  logic [IW-1:0]       clr_cnt;
  logic [IW-1:0]       idx;
  logic [1:0]          mode;
  logic [RTT_BITS-1:0] x;
  entry_t              ent;
  logic [RTT_BITS-1:0] ad;
  logic [RTT_BITS-1:0] ns;
  logic                low;

  logic                req_fire;
  logic                out_free;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  entry_t              wr_data;
  entry_t              rd_ent;

  logic [SW-1:0]       rtt_ext;
  logic [RTT_BITS-1:0] sample_sat;

  logic                neg;
  logic [RTT_BITS-1:0] ad_now;
  logic [RTT_BITS-1:0] q8;

  logic [AW-1:0]       acc31;
  logic [AW-1:0]       acc3;
  logic [RTT_BITS-1:0] nm;
  logic [RTT_BITS-1:0] half;
  logic [RTT_BITS-1:0] seed_dev;
  entry_t              ent_upd;

  logic [TW-1:0]       rto_sum;
  logic [pwre_pkg::RTO_W-1:0] rto_sat;
  logic                div_start;
  logic [RTT_BITS-1:0] div_dvs;
  logic                div_busy;
  logic                div_done;
  logic [pwre_pkg::RATE_W-1:0] div_quot;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  // saturate the sample to the estimator width
  always_comb begin
    rtt_ext    = SW'(req.rtt_us);
    sample_sat = (rtt_ext > SW'(RTT_MAX)) ? RTT_MAX : RTT_BITS'(rtt_ext);
  end

  // first update step: difference, smoothed time, low-side compare
  always_comb begin
    neg    = x < rd_ent.srtt;
    ad_now = neg ? (rd_ent.srtt - x) : (x - rd_ent.srtt);
    q8     = ad_now >> 3;
  end

  // second update step: deviation, maximum deviation, variance; rate cut on a timeout
  always_comb begin
    acc31    = (AW'(ent.mdev) << 5) - AW'(ent.mdev) + AW'(ad);
    acc3     = (AW'(ent.mdev) << 1) + AW'(ent.mdev) + AW'(ad);
    nm       = low ? RTT_BITS'(acc31 >> 5) : RTT_BITS'(acc3 >> 2);
    half     = x >> 1;
    seed_dev = (half > RTT_BITS'(pwre_pkg::SEED_FLOOR)) ? half
                                                         : RTT_BITS'(pwre_pkg::SEED_FLOOR);
    ent_upd  = ent;
    if (mode == pwre_pkg::MODE_SAMPLE) begin
      if (ent.srtt == '0) begin
        ent_upd.srtt   = x;
        ent_upd.mdev   = half;
        ent_upd.maxdev = seed_dev;
        ent_upd.rttvar = seed_dev;
      end else begin
        ent_upd.srtt = ns;
        ent_upd.mdev = nm;
        if (nm > ent.maxdev) begin
          ent_upd.maxdev = nm;
          if (nm > ent.rttvar) begin
            ent_upd.rttvar = nm;
          end
        end
      end
    end else if (mode == pwre_pkg::MODE_TIMEOUT) begin
      ent_upd.rate = ent.rate >> 2;
    end
  end

  // third update step: timeout and divider launch
  always_comb begin
    rto_sum   = TW'(ent.srtt) + (TW'(ent.rttvar) << 2);
    rto_sat   = (rto_sum > TW'(pwre_pkg::RTO_MAX)) ? pwre_pkg::RTO_MAX
                                                   : pwre_pkg::RTO_W'(rto_sum);
    div_start = (state == S_UPD3);
    div_dvs   = (ent.srtt == '0) ? RTT_BITS'(1) : ent.srtt;
  end

  // RAM write port: clearing pass or write-back
  always_comb begin
    wr_en   = (state == S_CLEAR) || ((state == S_WRITE) && out_free);
    wr_addr = (state == S_CLEAR) ? clr_cnt : idx;
    wr_data = (state == S_CLEAR) ? RESET_ENTRY : ent;
  end

  pwre_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_WORKERS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx),
    .rd_data (rd_ent)
  );

  pwre_div #(
    .DIV_W (RTT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  // sequencer, working registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // result valid: set by the write-back, cleared when taken
      if ((state == S_WRITE) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + IW'(1);
          if (clr_cnt == IW'(NUM_WORKERS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            mode  <= req.mode;
            idx   <= worker_mod(req.worker);
            x     <= sample_sat;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_UPD1;
        end
        S_UPD1: begin
          ent   <= rd_ent;
          ad    <= ad_now;
          ns    <= neg ? (rd_ent.srtt - q8) : (rd_ent.srtt + q8);
          low   <= ({1'b0, x} + {1'b0, rd_ent.mdev}) < {1'b0, rd_ent.srtt};
          state <= S_UPD2;
        end
        S_UPD2: begin
          ent   <= ent_upd;
          state <= (mode == pwre_pkg::MODE_SAMPLE) ? S_UPD3 : S_WRITE;
        end
        S_UPD3: begin
          ent.rto <= rto_sat;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            ent.rate <= div_quot;
            state    <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            rsp.rto_us       <= ent.rto;
            rsp.reqs_per_sec <= ent.rate;
            state            <= S_IDLE;
          end
        end
      endcase
    end
  end

  // the divider runs only while the sequencer waits for it
  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == S_DIV))
    else $error("divider busy outside its wait state");

  // no item is taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !req_ready)
    else $error("item accepted during clearing pass");

  // a write-back is followed by a pending result
  a_wb_result: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (state == S_WRITE)) |=> rsp_valid)
    else $error("write-back without result");

  // stored rate never exceeds the numerator
  a_rate_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_data.rate <= pwre_pkg::RATE_NUM))
    else $error("rate estimate out of range");

endmodule

`default_nettype wire

[hw/rtl/pwre_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module pwre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                           wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[hw/rtl/pwre_div.sv]
// Restoring divider, one quotient bit per cycle: computes 1e6 / divisor.
// Depends on pwre_pkg for the numerator and the quotient width.
`default_nettype none

module pwre_div #(
  parameter int DIV_W = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [DIV_W-1:0]            divisor,
  output logic                             busy,
  output logic                             done,
  output logic [pwre_pkg::RATE_W-1:0]      quotient
);

  localparam int QW    = pwre_pkg::RATE_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic [QW-1:0]    q;
  logic [DIV_W:0]   rem;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;

  logic [DIV_W:0]   rem_sh;
  logic             ge;
  logic [DIV_W:0]   rem_next;

  // one shift-subtract step
  always_comb begin
    rem_sh   = {rem[DIV_W-1:0], q[QW-1]};
    ge       = rem_sh >= {1'b0, dvs};
    rem_next = ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
  end

  // iteration control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q    <= pwre_pkg::RATE_NUM;
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        q   <= {q[QW-2:0], ge};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q;

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for per_worker_rtt_rto_estimator: directed table, then random
// items, every result compared against a hand-typed value or a behavioral round-trip
// estimator kept in the testbench. Depends on pwre_pkg and the estimator RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // mode code with no package name: the block handles it as a query
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int N_WORKERS   = 16;
  localparam int N_ITEMS     = 1950;
  localparam int N_DIRECTED  = 23;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 40;
  localparam int HOLD_OFF    = 600;

  // one row of the directed table; has_want marks a hand-typed result
  typedef struct packed {
    logic [1:0]                  mode;
    logic [3:0]                  worker;
    logic [23:0]                 rtt_us;
    logic                        has_want;
    logic [pwre_pkg::RTO_W-1:0]  want_rto;
    logic [pwre_pkg::RATE_W-1:0] want_rate;
  } plan_row_t;

  localparam plan_row_t PLAN [N_DIRECTED] = '{
    '{pwre_pkg::MODE_QUERY,   4'd0,  24'd0,      1'b1, 27'd200000,   20'd100000},
    '{pwre_pkg::MODE_TIMEOUT, 4'd1,  24'd0,      1'b1, 27'd200000,   20'd25000},
    '{pwre_pkg::MODE_TIMEOUT, 4'd1,  24'h123456, 1'b1, 27'd200000,   20'd6250},
    '{MODE_SPARE,             4'd2,  24'hFFFFFF, 1'b1, 27'd200000,   20'd100000},
    '{pwre_pkg::MODE_SAMPLE,  4'd3,  24'd0,      1'b1, 27'd200000,   20'd1000000},
    '{pwre_pkg::MODE_SAMPLE,  4'd3,  24'd0,      1'b1, 27'd200000,   20'd1000000},
    '{pwre_pkg::MODE_SAMPLE,  4'd4,  24'hFFFFFF, 1'b1, 27'd50331643, 20'd0},
    '{pwre_pkg::MODE_TIMEOUT, 4'd4,  24'd0,      1'b1, 27'd50331643, 20'd0},
    '{pwre_pkg::MODE_SAMPLE,  4'd5,  24'd1000,   1'b1, 27'd201000,   20'd1000},
    '{pwre_pkg::MODE_SAMPLE,  4'd5,  24'd1000,   1'b0, 27'd0,        20'd0},
    '{pwre_pkg::MODE_SAMPLE,  4'd5,  24'd200,    1'b0, 27'd0,        20'd0},
    '{pwre_pkg::MODE_SAMPLE,  4'd5,  24'd800000, 1'b0, 27'd0,        20'd0},
    '{pwre_pkg::MODE_TIMEOUT, 4'd5,  24'd7,      1'b0, 27'd0,        20'd0},
    '{pwre_pkg::MODE_QUERY,   4'd5,  24'hFFFFFF, 1'b0, 27'd0,        20'd0},
    '{pwre_pkg::MODE_SAMPLE,  4'd6,  24'd300000, 1'b1, 27'd900000,   20'd3},
    '{pwre_pkg::MODE_SAMPLE,  4'd6,  24'd0,      1'b0, 27'd0,        20'd0},
    '{pwre_pkg::MODE_SAMPLE,  4'd6,  24'hFFFFFF, 1'b0, 27'd0,        20'd0},
    '{pwre_pkg::MODE_SAMPLE,  4'd15, 24'd1,      1'b1, 27'd200001,   20'd1000000},
    '{pwre_pkg::MODE_SAMPLE,  4'd15, 24'd0,      1'b0, 27'd0,        20'd0},
    '{pwre_pkg::MODE_QUERY,   4'd15, 24'd0,      1'b0, 27'd0,        20'd0},
    '{pwre_pkg::MODE_SAMPLE,  4'd0,  24'hAAAAAA, 1'b0, 27'd0,        20'd0},
    '{pwre_pkg::MODE_SAMPLE,  4'd0,  24'h555555, 1'b0, 27'd0,        20'd0},
    '{pwre_pkg::MODE_TIMEOUT, 4'd3,  24'd0,      1'b0, 27'd0,        20'd0}
  };

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b0;
  pwre_pkg::req_t req = '0;
  logic req_ready;
  logic rsp_valid;
  pwre_pkg::rsp_t rsp;

  per_worker_rtt_rto_estimator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // per-worker estimator state as the block should hold it
  logic [23:0]                 srtt_tab     [N_WORKERS];
  logic [23:0]                 mdev_tab     [N_WORKERS];
  logic [23:0]                 mdev_max_tab [N_WORKERS];
  logic [23:0]                 rttvar_tab   [N_WORKERS];
  logic [pwre_pkg::RATE_W-1:0] rate_tab     [N_WORKERS];
  logic [pwre_pkg::RTO_W-1:0]  rto_tab      [N_WORKERS];

  pwre_pkg::rsp_t pending_replies [$];
  int   err_count   = 0;
  int   sent_count  = 0;
  int   reply_count = 0;
  int   cycle_count = 0;
  int   mode_count [4] = '{0, 0, 0, 0};

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d replies missing", $time, cycle_count,
               pending_replies.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // stretches with no idling on either side
  function automatic bit quiet_span(int n);
    return (n >= 600 && n < 750) || (n >= 1500 && n < 1580);
  endfunction

  // advance one worker's estimator for an item and return its reply
  function automatic pwre_pkg::rsp_t estimate_reply(pwre_pkg::req_t r);
    longint s, m, x, d, ad, ns, nm, sum;
    int     w;
    pwre_pkg::rsp_t o;
    w = int'(r.worker);
    if (r.mode == pwre_pkg::MODE_SAMPLE) begin
      x = longint'(r.rtt_us);
      if (srtt_tab[w] == '0) begin
        // first sample seeds the entry
        srtt_tab[w]     = r.rtt_us;
        mdev_tab[w]     = r.rtt_us >> 1;
        mdev_max_tab[w] = ((r.rtt_us >> 1) > pwre_pkg::SEED_FLOOR) ? (r.rtt_us >> 1)
                                                                     : 24'(pwre_pkg::SEED_FLOOR);
        rttvar_tab[w]   = mdev_max_tab[w];
      end else begin
        s  = longint'(srtt_tab[w]);
        m  = longint'(mdev_tab[w]);
        d  = x - s;
        ad = (d < 0) ? -d : d;
        ns = s + d / 8;
        // small gain when the sample falls well below the mean
        if (x < s - m) nm = (31 * m + ad) / 32;
        else nm = (3 * m + ad) / 4;
        if (nm > longint'(mdev_max_tab[w])) begin
          mdev_max_tab[w] = nm[23:0];
          if (mdev_max_tab[w] > rttvar_tab[w]) rttvar_tab[w] = mdev_max_tab[w];
        end
        srtt_tab[w] = (ns > 64'hFFFFFF) ? 24'hFFFFFF : ns[23:0];
        mdev_tab[w] = (nm > 64'hFFFFFF) ? 24'hFFFFFF : nm[23:0];
      end
      s   = longint'(srtt_tab[w]);
      sum = s + 4 * longint'(rttvar_tab[w]);
      rto_tab[w] = (sum > longint'(pwre_pkg::RTO_MAX)) ? pwre_pkg::RTO_MAX
                                                       : sum[pwre_pkg::RTO_W-1:0];
      // zero divisor counts as one
      nm  = longint'(pwre_pkg::RATE_NUM) / ((s == 0) ? 64'd1 : s);
      rate_tab[w] = (nm > 64'hFFFFF) ? 20'hFFFFF : nm[pwre_pkg::RATE_W-1:0];
    end else if (r.mode == pwre_pkg::MODE_TIMEOUT) begin
      rate_tab[w] = rate_tab[w] >> 2;
    end
    o.rto_us       = rto_tab[w];
    o.reqs_per_sec = rate_tab[w];
    return o;
  endfunction

  // random item, mostly samples near the worker's current estimate
  function automatic pwre_pkg::req_t random_item();
    pwre_pkg::req_t r;
    int     pick;
    longint base, jit, v;
    pick     = int'($urandom_range(0, 99));
    r.worker = 4'($urandom_range(0, N_WORKERS - 1));
    r.rtt_us = 24'($urandom);
    if (pick < 62) r.mode = pwre_pkg::MODE_SAMPLE;
    else if (pick < 80) r.mode = pwre_pkg::MODE_TIMEOUT;
    else if (pick < 95) r.mode = pwre_pkg::MODE_QUERY;
    else r.mode = MODE_SPARE;
    if (r.mode == pwre_pkg::MODE_SAMPLE) begin
      case ($urandom_range(0, 9))
        0: r.rtt_us = 24'($urandom);
        1: r.rtt_us = 24'($urandom_range(0, 255));
        2: r.rtt_us = '0;
        3: r.rtt_us = 24'hFFFFFF - 24'($urandom_range(0, 1000));
        default: begin
          base = longint'(srtt_tab[r.worker]);
          if (base == 0) base = longint'($urandom_range(1000, 300000));
          jit = longint'($urandom_range(0, int'(base)));
          if ($urandom_range(0, 1) == 1) v = base + jit;
          else v = base - jit;
          r.rtt_us = (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
        end
      endcase
    end
    return r;
  endfunction

  // offer one item after a random gap and log its reply once accepted
  task automatic send_item(pwre_pkg::req_t item, bit has_want, pwre_pkg::rsp_t want);
    int   gap;
    pwre_pkg::rsp_t got;
    gap = quiet_span(sent_count) ? 0 : int'($urandom_range(0, 17));
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_ready !== 1'b1);
    got = estimate_reply(item);
    pending_replies = {pending_replies, (has_want ? want : got)};
    mode_count[item.mode] = mode_count[item.mode] + 1;
    sent_count = sent_count + 1;
  endtask

  // receiver: random stalls, long hold-offs to back the block up
  initial begin : reply_side
    int   stall;
    pwre_pkg::rsp_t want;
    forever begin
      if (reply_count == 150 || reply_count == 1200) stall = HOLD_OFF;
      else if (quiet_span(reply_count)) stall = 0;
      else stall = int'($urandom_range(0, 17));
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (rsp_valid !== 1'b1);
      reply_count = reply_count + 1;
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with none expected, got rto %0d rate %0d", $time,
                 rsp.rto_us, rsp.reqs_per_sec);
        err_count = err_count + 1;
      end else begin
        want = pending_replies[0];
        pending_replies.delete(0);
        if (rsp.rto_us !== want.rto_us) begin
          $display("%0t: rto_us mismatch, expected %0d, got %0d", $time,
                   want.rto_us, rsp.rto_us);
          err_count = err_count + 1;
        end
        if (rsp.reqs_per_sec !== want.reqs_per_sec) begin
          $display("%0t: reqs_per_sec mismatch, expected %0d, got %0d", $time,
                   want.reqs_per_sec, rsp.reqs_per_sec);
          err_count = err_count + 1;
        end
      end
    end
  end

  // reset, directed table, random items, drain
  initial begin : item_side
    pwre_pkg::rsp_t want;
    pwre_pkg::req_t item;
    for (int w = 0; w < N_WORKERS; w++) begin
      srtt_tab[w]     = '0;
      mdev_tab[w]     = '0;
      mdev_max_tab[w] = '0;
      rttvar_tab[w]   = '0;
      rate_tab[w]     = pwre_pkg::RATE_RESET;
      rto_tab[w]      = pwre_pkg::RTO_RESET;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < N_DIRECTED; k++) begin
      item.mode         = PLAN[k].mode;
      item.worker       = PLAN[k].worker;
      item.rtt_us       = PLAN[k].rtt_us;
      want.rto_us       = PLAN[k].want_rto;
      want.reqs_per_sec = PLAN[k].want_rate;
      send_item(item, PLAN[k].has_want, want);
    end

    want = '0;
    while (sent_count < N_ITEMS) send_item(random_item(), 1'b0, want);
    req_valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("items: %0d samples, %0d timeouts, %0d queries, %0d spare-mode queries",
             mode_count[pwre_pkg::MODE_SAMPLE], mode_count[pwre_pkg::MODE_TIMEOUT],
             mode_count[pwre_pkg::MODE_QUERY], mode_count[MODE_SPARE]);
    $display("replies checked: %0d over %0d cycles, %0d errors", reply_count, cycle_count,
             err_count);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
